/* rtl/core/gwpp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwpp_pkg: shared types and constants of the windowed peak picker
// Payload structs, register indexes, exponent tables and datapath widths.
// ----------------------------------------------------------------------------
package gwpp_pkg;

  // circular store geometry
  localparam int ADDR_W       = 11;
  localparam int BUFFER_DEPTH = 1 << ADDR_W;
  localparam int SAMPLE_BITS  = 16;
  localparam int SAMPLE_MAX_W = 24;

  // request opcodes
  localparam logic OP_STORE  = 1'b0;
  localparam logic OP_DETECT = 1'b1;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SPACING  = 2'd1;
  localparam logic [11:0] MIN_SPACING_RESET = 12'd256;

  // shared divider widths
  localparam int NUM_W = 56;
  localparam int DEN_W = 34;
  localparam int QUO_W = 10;

  // shared multiplier widths
  localparam int MUL_A_W = 24;
  localparam int MUL_B_W = 33;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // x/5 for x < 2^21 as (x*K) >> 24
  localparam logic [21:0] DIV5_MUL   = 22'd3355444;
  localparam int          DIV5_SHIFT = 24;

  typedef struct packed {
    logic                     op;
    logic [ADDR_W-1:0]        position;
    logic signed [15:0]       sample;
  } item_t;

  typedef struct packed {
    logic        peak_found;
    logic        tracking;
    logic [18:0] peak_center;
    logic [10:0] peak_origin;
    logic [12:0] peak_distance;
    logic [18:0] next_center;
  } result_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic             ovf;
    logic [QUO_W-1:0] quot;
  } div_rsp_t;

  // exp(-k) in Q16, k = 0..39
  function automatic logic [16:0] exp_int_q16(input logic [5:0] k);
    logic [16:0] r;
    case (k)
      6'd0:    r = 17'd65536;
      6'd1:    r = 17'd24109;
      6'd2:    r = 17'd8869;
      6'd3:    r = 17'd3263;
      6'd4:    r = 17'd1200;
      6'd5:    r = 17'd442;
      6'd6:    r = 17'd162;
      6'd7:    r = 17'd60;
      6'd8:    r = 17'd22;
      6'd9:    r = 17'd8;
      6'd10:   r = 17'd3;
      6'd11:   r = 17'd1;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

  // exp(-f/16) in Q16, f = 0..15
  function automatic logic [16:0] exp_frac_q16(input logic [3:0] f);
    logic [16:0] r;
    case (f)
      4'd0:    r = 17'd65536;
      4'd1:    r = 17'd61565;
      4'd2:    r = 17'd57836;
      4'd3:    r = 17'd54331;
      4'd4:    r = 17'd51039;
      4'd5:    r = 17'd47947;
      4'd6:    r = 17'd45042;
      4'd7:    r = 17'd42313;
      4'd8:    r = 17'd39750;
      4'd9:    r = 17'd37341;
      4'd10:   r = 17'd35079;
      4'd11:   r = 17'd32954;
      4'd12:   r = 17'd30957;
      4'd13:   r = 17'd29081;
      4'd14:   r = 17'd27319;
      default: r = 17'd25664;
    endcase
    return r;
  endfunction

endpackage

/* rtl/core/gwpp_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwpp_store: circular sample memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module gwpp_store #(
  parameter int DATA_W = gwpp_pkg::SAMPLE_BITS
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [gwpp_pkg::ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0]           wdata,
  input  logic                        re,
  input  logic [gwpp_pkg::ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0]           rdata
);

  logic [DATA_W-1:0] mem [gwpp_pkg::BUFFER_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/gwpp_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwpp_div: shared restoring divider
// One quotient bit per cycle, QUO_W bits, with an overflow flag when the
// quotient does not fit.
// ----------------------------------------------------------------------------
module gwpp_div (
  input  logic               clk,
  input  logic               rst,
  input  gwpp_pkg::div_req_t req,
  output gwpp_pkg::div_rsp_t rsp
);

  localparam int QW = gwpp_pkg::QUO_W;
  localparam int NW = gwpp_pkg::NUM_W;
  localparam int CW = $clog2(QW);

  logic [NW-1:0] rem;
  logic [NW-1:0] dsh;
  logic [QW-1:0] quot;
  logic [CW-1:0] cnt;
  logic          busy;
  logic          fin;
  logic          ovf;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      cnt  <= '0;
    end else begin
      fin <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CW'(QW - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  // datapath: compare and subtract the shifted divisor
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem  <= req.num;
      dsh  <= NW'(req.den) << (QW - 1);
      ovf  <= req.num >= (NW'(req.den) << QW);
      quot <= '0;
    end else if (busy) begin
      if (rem >= dsh) begin
        rem  <= rem - dsh;
        quot <= {quot[QW-2:0], 1'b1};
      end else begin
        quot <= {quot[QW-2:0], 1'b0};
      end
      dsh <= dsh >> 1;
    end
  end

  assign rsp.done = fin;
  assign rsp.ovf  = ovf;
  assign rsp.quot = quot;

`ifndef SYNTHESIS
  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !busy)
    else $error("divider started while busy");
`endif

endmodule

/* rtl/core/gaussian_windowed_peak_picker_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gaussian_windowed_peak_picker_unit: windowed peak picker, parabolic refine
// Stores samples in a circular buffer and, on detect requests, tracks the
// Gaussian-weighted maximum and publishes a refined peak.
// ----------------------------------------------------------------------------
// Usage:
//   item channel (item_valid/item_stall/item): one request per transfer,
//   either a sample store or a detect at the write head.
//   result channel (result_valid/result_stall/result): one result for every
//   request, in order.
//   cfg channel (cfg_valid/cfg_ready, always ready): window_width and
//   min_spacing, written while the block is idle.
// Sequencing: a store goes straight to the output register. A detect
//   evaluates one weighted sample (unweighted when the window width is 0,
//   else through the 10-step shared divider); one that closes a peak
//   evaluates three more and divides again unless the curvature is zero.
// Throughput: one request at a time; item_stall stays high until the result
//   has been moved into the output register.
// Reset: rst (synchronous) clears all held peak state and the registers to
//   their defaults; sample memory is not cleared.
// Stall: a stalled result holds; the block waits with the next result ready.
// ----------------------------------------------------------------------------
module gaussian_windowed_peak_picker_unit #(
  parameter int SAMPLE_BITS = gwpp_pkg::SAMPLE_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_stall,
  input  gwpp_pkg::item_t                     item,
  output logic                                result_valid,
  input  logic                                result_stall,
  output gwpp_pkg::result_t                   result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [gwpp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [15:0]                         cfg_data
);

  localparam int AW   = gwpp_pkg::ADDR_W;
  localparam int SB   = SAMPLE_BITS;
  localparam int WR_W = SB + 1;
  localparam int PW   = gwpp_pkg::PROD_W;

  // sequencer codes
  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_WRD   = 5'd1;
  localparam logic [4:0] S_WD8   = 5'd2;
  localparam logic [4:0] S_WSQ   = 5'd3;
  localparam logic [4:0] S_WNUM  = 5'd4;
  localparam logic [4:0] S_WDEN  = 5'd5;
  localparam logic [4:0] S_WDIV  = 5'd6;
  localparam logic [4:0] S_WGAIN = 5'd7;
  localparam logic [4:0] S_WMAG  = 5'd8;
  localparam logic [4:0] S_WRND  = 5'd9;
  localparam logic [4:0] S_DISP  = 5'd10;
  localparam logic [4:0] S_F0    = 5'd11;
  localparam logic [4:0] S_F1    = 5'd12;
  localparam logic [4:0] S_F2    = 5'd13;
  localparam logic [4:0] S_F3    = 5'd14;
  localparam logic [4:0] S_F4    = 5'd15;
  localparam logic [4:0] S_OUT   = 5'd16;

  // which weighted sample is being evaluated
  localparam logic [1:0] PH_DET = 2'd0;
  localparam logic [1:0] PH_PRV = 2'd1;
  localparam logic [1:0] PH_CTR = 2'd2;
  localparam logic [1:0] PH_NXT = 2'd3;

  logic [4:0] state;
  logic [1:0] ph;

  // configuration registers
  logic [15:0] window_width;
  logic [11:0] min_spacing;

  // peak state
  logic [AW-1:0]         origin;
  logic [AW-1:0]         peak_position;
  logic                  tracking_flag;
  logic [15:0]           width_in_use;
  logic [18:0]           center_position;
  logic signed [WR_W-1:0] peak_level;
  logic [12:0]           last_distance;
  logic [18:0]           predicted_center;
  logic                  found;

  // working registers
  logic [AW-1:0]          pos;
  logic [AW-1:0]          idx;
  logic [12:0]            head_dist;
  logic [SB-1:0]          mag;
  logic [21:0]            d8a;
  logic [gwpp_pkg::NUM_W-1:0] numr;
  logic [9:0]             q4;
  logic signed [WR_W-1:0] wres;
  logic signed [WR_W-1:0] wprv;
  logic signed [WR_W-1:0] wctr;
  logic signed [WR_W-1:0] wnxt;
  logic                   osign;
  logic signed [8:0]      off;
  logic [PW-1:0]          prod;

  logic accept;
  logic store_we;
  logic [SB-1:0] sval;
  logic [SB-1:0] rdata;

  gwpp_pkg::div_req_t div_req;
  gwpp_pkg::div_rsp_t div_rsp;

  assign cfg_ready  = 1'b1;
  assign item_stall = (state != S_IDLE);
  assign accept     = item_valid && !item_stall;
  assign store_we   = accept && (item.op == gwpp_pkg::OP_STORE);

  // stored: low SAMPLE_BITS bits (zero-extended past 16), top bit as sign
  generate
    if (SB <= 16) begin : g_narrow
      assign sval = item.sample[SB-1:0];
    end else begin : g_wide
      assign sval = SB'(item.sample[15:0]);
    end
  endgenerate

  gwpp_store #(
    .DATA_W (SB)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (item.position),
    .wdata (sval),
    .re    (state == S_WRD),
    .raddr (idx),
    .rdata (rdata)
  );

  gwpp_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // unwrapped index helpers
  logic [AW:0] u_idx;
  logic [AW:0] u_pp;
  assign u_idx = (idx > origin) ? {1'b0, idx} : {1'b1, idx};
  assign u_pp  = (peak_position > origin) ? {1'b0, peak_position}
                                          : {1'b1, peak_position};

  // distance from the window center, Q8
  logic signed [22:0] d8;
  assign d8 = $signed({3'b0, u_idx, 8'b0}) - $signed({4'b0, center_position})
            - $signed({3'b0, width_in_use, 4'b0});

  logic signed [SB-1:0] s_rd;
  assign s_rd = $signed(rdata);

  // parabola terms
  logic signed [WR_W+1:0] pdiff;
  logic signed [WR_W+1:0] curv;
  logic [WR_W+1:0] pdiff_abs;
  logic [WR_W+1:0] curv_abs;
  assign pdiff     = (WR_W+2)'(wnxt) - (WR_W+2)'(wprv);
  assign curv      = ((WR_W+2)'(wctr) <<< 1) - (WR_W+2)'(wnxt) - (WR_W+2)'(wprv);
  assign pdiff_abs = pdiff[WR_W+1] ? (WR_W+2)'(-pdiff) : pdiff;
  assign curv_abs  = curv[WR_W+1] ? (WR_W+2)'(-curv) : curv;

  // divider request
  always_comb begin
    div_req.start = (state == S_WDEN) || ((state == S_F0) && (curv != '0));
    if (state == S_F0) begin
      div_req.num = gwpp_pkg::NUM_W'(pdiff_abs) << 7;
      div_req.den = gwpp_pkg::DEN_W'(curv_abs);
    end else begin
      div_req.num = numr;
      div_req.den = gwpp_pkg::DEN_W'(prod[31:0]) + (gwpp_pkg::DEN_W'(prod[31:0]) << 1);
    end
  end

  // shared multiplier operands
  logic [gwpp_pkg::MUL_A_W-1:0] mul_a;
  logic [gwpp_pkg::MUL_B_W-1:0] mul_b;
  always_comb begin
    case (state)
      S_WSQ: begin
        mul_a = gwpp_pkg::MUL_A_W'(d8a);
        mul_b = gwpp_pkg::MUL_B_W'(d8a);
      end
      S_WNUM: begin
        mul_a = gwpp_pkg::MUL_A_W'(width_in_use);
        mul_b = gwpp_pkg::MUL_B_W'(width_in_use);
      end
      S_WGAIN: begin
        mul_a = gwpp_pkg::MUL_A_W'(gwpp_pkg::exp_int_q16(q4[9:4]));
        mul_b = gwpp_pkg::MUL_B_W'(gwpp_pkg::exp_frac_q16(q4[3:0]));
      end
      S_WMAG: begin
        mul_a = gwpp_pkg::MUL_A_W'(mag);
        mul_b = prod[gwpp_pkg::MUL_B_W-1:0];
      end
      S_F3: begin
        mul_a = gwpp_pkg::MUL_A_W'({width_in_use, 5'b0} + 21'd2);
        mul_b = gwpp_pkg::MUL_B_W'(gwpp_pkg::DIV5_MUL);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // tracking window test and finalize terms
  logic        in_window;
  logic [8:0]  qmag;
  logic [18:0] c8;
  logic [19:0] c8_round;
  logic [PW:0] rnd_sum;
  assign in_window = (20'(head_dist) * 20'd80) <= (20'(width_in_use) * 20'd6);
  assign qmag      = (div_rsp.ovf || div_rsp.quot >= 10'd128) ? 9'd128
                                                              : 9'(div_rsp.quot);
  assign c8        = {peak_position, 8'b0} + 19'(off);
  assign c8_round  = 20'(c8) + 20'd128;
  assign rnd_sum   = (PW+1)'(prod) + ((PW+1)'(1) << 31);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      window_width <= '0;
      min_spacing  <= gwpp_pkg::MIN_SPACING_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        gwpp_pkg::REG_WINDOW_WIDTH: window_width <= cfg_data;
        gwpp_pkg::REG_MIN_SPACING:  min_spacing  <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // sequencer and peak state
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      ph               <= PH_DET;
      origin           <= '0;
      peak_position    <= '0;
      tracking_flag    <= 1'b0;
      width_in_use     <= '0;
      center_position  <= '0;
      peak_level       <= '0;
      last_distance    <= '0;
      predicted_center <= '0;
      found            <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            found <= 1'b0;
            pos   <= item.position;
            idx   <= item.position;
            ph    <= PH_DET;
            head_dist <= 13'((item.position > origin) ? {1'b0, item.position}
                                                      : {1'b1, item.position})
                       - 13'(origin);
            if (item.op == gwpp_pkg::OP_DETECT) begin
              if (!tracking_flag) begin
                width_in_use <= window_width;
              end
              state <= S_WRD;
            end else begin
              state <= S_OUT;
            end
          end
        end
        S_WRD: state <= S_WD8;
        S_WD8: begin
          mag <= s_rd[SB-1] ? SB'(-s_rd) : SB'(s_rd);
          d8a <= d8[22] ? 22'(-d8) : 22'(d8);
          if (width_in_use == '0) begin
            wres  <= WR_W'(s_rd);
            state <= S_DISP;
          end else begin
            state <= S_WSQ;
          end
        end
        S_WSQ: state <= S_WNUM;
        S_WNUM: begin
          // d8^2 * 625
          numr  <= (gwpp_pkg::NUM_W'(prod[43:0]) << 9) + (gwpp_pkg::NUM_W'(prod[43:0]) << 6)
                 + (gwpp_pkg::NUM_W'(prod[43:0]) << 5) + (gwpp_pkg::NUM_W'(prod[43:0]) << 4)
                 + gwpp_pkg::NUM_W'(prod[43:0]);
          state <= S_WDEN;
        end
        S_WDEN: state <= S_WDIV;
        S_WDIV: begin
          if (div_rsp.done) begin
            if (div_rsp.ovf || div_rsp.quot >= 10'd640) begin
              wres  <= '0;
              state <= S_DISP;
            end else begin
              q4    <= div_rsp.quot;
              state <= S_WGAIN;
            end
          end
        end
        S_WGAIN: state <= S_WMAG;
        S_WMAG:  state <= S_WRND;
        S_WRND: begin
          wres  <= $signed(WR_W'(rnd_sum >> 32));
          state <= S_DISP;
        end
        S_DISP: begin
          case (ph)
            PH_DET: begin
              state <= S_OUT;
              if (!tracking_flag) begin
                if (head_dist >= 13'(min_spacing)) begin
                  peak_level    <= wres;
                  peak_position <= pos;
                  tracking_flag <= 1'b1;
                end
              end else if (in_window) begin
                if (wres > peak_level) begin
                  peak_level    <= wres;
                  peak_position <= pos;
                end
              end else begin
                idx   <= peak_position - 1'b1;
                ph    <= PH_PRV;
                state <= S_WRD;
              end
            end
            PH_PRV: begin
              wprv  <= wres;
              idx   <= peak_position;
              ph    <= PH_CTR;
              state <= S_WRD;
            end
            PH_CTR: begin
              wctr  <= wres;
              idx   <= peak_position + 1'b1;
              ph    <= PH_NXT;
              state <= S_WRD;
            end
            default: begin
              wnxt  <= wres;
              state <= S_F0;
            end
          endcase
        end
        S_F0: begin
          osign <= pdiff[WR_W+1] ^ curv[WR_W+1];
          if (curv == '0) begin
            off   <= '0;
            state <= S_F2;
          end else begin
            state <= S_F1;
          end
        end
        S_F1: begin
          if (div_rsp.done) begin
            off   <= osign ? -$signed(qmag) : $signed(qmag);
            state <= S_F2;
          end
        end
        S_F2: begin
          center_position <= c8;
          origin          <= c8_round[18:8];
          last_distance   <= 13'(u_pp) - 13'(origin);
          tracking_flag   <= 1'b0;
          found           <= 1'b1;
          state           <= S_F3;
        end
        S_F3: state <= S_F4;
        S_F4: begin
          predicted_center <= center_position - prod[gwpp_pkg::DIV5_SHIFT +: 19];
          state            <= S_OUT;
        end
        S_OUT: begin
          if (!result_valid || !result_stall) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == S_OUT && (!result_valid || !result_stall)) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && (!result_valid || !result_stall)) begin
      result.peak_found    <= found;
      result.tracking      <= tracking_flag;
      result.peak_center   <= center_position;
      result.peak_origin   <= origin;
      result.peak_distance <= last_distance;
      result.next_center   <= predicted_center;
    end
  end

`ifndef SYNTHESIS
  a_found_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(result.peak_found && result.tracking))
    else $error("peak reported while still tracking");

  a_width_held: assert property (@(posedge clk) disable iff (rst)
    (tracking_flag && $past(tracking_flag)) |-> $stable(width_in_use))
    else $error("window width changed during tracking");

  a_origin_move: assert property (@(posedge clk) disable iff (rst)
    (origin != $past(origin)) |-> ($past(state) == S_F2))
    else $error("origin moved outside finalize");

  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == S_WDIV || state == S_F1))
    else $error("divider result with no consumer");
`endif

endmodule
